/* sv/scl_pkg.sv */
// shared constants and types of the shell command tokenizer
package scl_pkg;

   // token kinds on the result channel
   localparam logic [3:0] TK_CHAR    = 4'd0;
   localparam logic [3:0] TK_WEND    = 4'd1;
   localparam logic [3:0] TK_NEWLINE = 4'd2;
   localparam logic [3:0] TK_PIPE    = 4'd3;
   localparam logic [3:0] TK_RIN     = 4'd4;
   localparam logic [3:0] TK_ROUT    = 4'd5;
   localparam logic [3:0] TK_APPEND  = 4'd6;
   localparam logic [3:0] TK_EOF     = 4'd7;
   localparam logic [3:0] TK_QERR    = 4'd8;

   // input command codes
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // lexer mode codes
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_WORD    = 4'd1;
   localparam logic [3:0] M_WORD_BS = 4'd2;
   localparam logic [3:0] M_SQ      = 4'd3;
   localparam logic [3:0] M_DQ      = 4'd4;
   localparam logic [3:0] M_DQ_BS   = 4'd5;
   localparam logic [3:0] M_COMMENT = 4'd6;
   localparam logic [3:0] M_GT      = 4'd7;
   localparam logic [3:0] M_ERROR   = 4'd8;

   // characters with special meaning
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_PIPE   = 8'h7C;

   // most results one input beat can cause
   localparam int MAX_RES = 3;

   // results of one input beat, slot 0 first
   typedef struct packed {
      logic [1:0]               count;
      logic [MAX_RES-1:0][3:0]  kind;
      logic [MAX_RES-1:0][7:0]  chr;
   } lex_set_type;

endpackage

/* sv/shell_command_tokenizer.sv */
// Shell command tokenizer: byte stream in, token stream out.
// The first result of a beat shows on rsp the cycle after the beat is taken.
// One byte per cycle while each byte makes at most one result and rsp_tready is high;
// a byte that makes more (up to 3) holds req_tready low while the result register
// drains, one result per cycle while rsp_tready is high, down to its last result.
// Reset (synchronous, active high) sets the lexer idle and empties the result register.
module shell_command_tokenizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // [3:0] token_kind, [11:4] word_char, [15:12] zero
   output logic         rsp_tlast    // last_of_run
);

   scl_pkg::lex_set_type  set;
   logic                  accept;
   logic [3:0]            out_kind;
   logic [7:0]            out_chr;

   assign accept = req_tvalid && req_tready;

   // token decode and mode state
   scl_step u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_tuser),
      .data_byte (req_tdata),
      .set       (set)
   );

   // result register and serializer
   scl_resq u_resq (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .set       (set),
      .pop_ready (rsp_tready),
      .can_load  (req_tready),
      .out_valid (rsp_tvalid),
      .out_kind  (out_kind),
      .out_chr   (out_chr),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, out_chr, out_kind};

endmodule

/* sv/scl_step.sv */
// lexer mode register and the per-beat token decode
module scl_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     command,
   input  logic [7:0]               data_byte,
   output scl_pkg::lex_set_type     set
);

   logic [3:0] mode_ff;
   logic [3:0] mode_in;

   // blank characters separate words
   function automatic logic is_blank(input logic [7:0] c);
      return c inside {scl_pkg::CH_SPACE, scl_pkg::CH_TAB, scl_pkg::CH_VT,
                       scl_pkg::CH_FF, scl_pkg::CH_CR};
   endfunction

   // decode of one beat
   always_comb begin
      logic [1:0]  n;
      logic        bnd;
      logic        brk;
      n       = 2'd0;
      bnd     = 1'b0;
      brk     = 1'b0;
      mode_in = mode_ff;
      set     = '0;
      if (command == scl_pkg::CMD_END) begin
         case (mode_ff)
            scl_pkg::M_WORD: begin
               set.kind[n] = scl_pkg::TK_WEND;
               n = n + 2'd1;
            end
            scl_pkg::M_WORD_BS: begin
               set.kind[n] = scl_pkg::TK_CHAR;
               set.chr[n]  = scl_pkg::CH_BSLASH;
               n = n + 2'd1;
               set.kind[n] = scl_pkg::TK_WEND;
               n = n + 2'd1;
            end
            scl_pkg::M_SQ, scl_pkg::M_DQ, scl_pkg::M_DQ_BS: begin
               set.kind[n] = scl_pkg::TK_QERR;
               n = n + 2'd1;
            end
            scl_pkg::M_GT: begin
               set.kind[n] = scl_pkg::TK_ROUT;
               n = n + 2'd1;
            end
            default: begin
            end
         endcase
         set.kind[n] = scl_pkg::TK_EOF;
         n = n + 2'd1;
         mode_in = scl_pkg::M_IDLE;
      end else begin
         brk = is_blank(data_byte) ||
               data_byte inside {scl_pkg::CH_NL, scl_pkg::CH_PIPE, scl_pkg::CH_LT,
                                 scl_pkg::CH_GT, scl_pkg::CH_HASH, scl_pkg::CH_NUL};
         case (mode_ff)
            scl_pkg::M_WORD: begin
               if (data_byte == scl_pkg::CH_SQUOTE) begin
                  mode_in = scl_pkg::M_SQ;
               end else if (data_byte == scl_pkg::CH_DQUOTE) begin
                  mode_in = scl_pkg::M_DQ;
               end else if (data_byte == scl_pkg::CH_BSLASH) begin
                  mode_in = scl_pkg::M_WORD_BS;
               end else if (brk) begin
                  set.kind[n] = scl_pkg::TK_WEND;
                  n = n + 2'd1;
                  bnd = 1'b1;
               end else begin
                  set.kind[n] = scl_pkg::TK_CHAR;
                  set.chr[n]  = data_byte;
                  n = n + 2'd1;
               end
            end
            scl_pkg::M_WORD_BS: begin
               set.kind[n] = scl_pkg::TK_CHAR;
               set.chr[n]  = data_byte;
               n = n + 2'd1;
               mode_in = scl_pkg::M_WORD;
            end
            scl_pkg::M_SQ: begin
               if (data_byte == scl_pkg::CH_SQUOTE) begin
                  mode_in = scl_pkg::M_WORD;
               end else begin
                  set.kind[n] = scl_pkg::TK_CHAR;
                  set.chr[n]  = data_byte;
                  n = n + 2'd1;
               end
            end
            scl_pkg::M_DQ: begin
               if (data_byte == scl_pkg::CH_DQUOTE) begin
                  mode_in = scl_pkg::M_WORD;
               end else if (data_byte == scl_pkg::CH_BSLASH) begin
                  mode_in = scl_pkg::M_DQ_BS;
               end else begin
                  set.kind[n] = scl_pkg::TK_CHAR;
                  set.chr[n]  = data_byte;
                  n = n + 2'd1;
               end
            end
            scl_pkg::M_DQ_BS: begin
               if (data_byte == scl_pkg::CH_NL) begin
                  set.kind[n] = scl_pkg::TK_QERR;
                  n = n + 2'd1;
                  mode_in = scl_pkg::M_ERROR;
               end else if (data_byte inside {scl_pkg::CH_DQUOTE, scl_pkg::CH_BSLASH,
                                              scl_pkg::CH_DOLLAR, scl_pkg::CH_BTICK}) begin
                  set.kind[n] = scl_pkg::TK_CHAR;
                  set.chr[n]  = data_byte;
                  n = n + 2'd1;
                  mode_in = scl_pkg::M_DQ;
               end else begin
                  set.kind[n] = scl_pkg::TK_CHAR;
                  set.chr[n]  = scl_pkg::CH_BSLASH;
                  n = n + 2'd1;
                  set.kind[n] = scl_pkg::TK_CHAR;
                  set.chr[n]  = data_byte;
                  n = n + 2'd1;
                  mode_in = scl_pkg::M_DQ;
               end
            end
            scl_pkg::M_COMMENT: begin
               if (data_byte == scl_pkg::CH_NL) begin
                  set.kind[n] = scl_pkg::TK_NEWLINE;
                  n = n + 2'd1;
                  mode_in = scl_pkg::M_IDLE;
               end
            end
            scl_pkg::M_GT: begin
               if (data_byte == scl_pkg::CH_GT) begin
                  set.kind[n] = scl_pkg::TK_APPEND;
                  n = n + 2'd1;
                  mode_in = scl_pkg::M_IDLE;
               end else begin
                  set.kind[n] = scl_pkg::TK_ROUT;
                  n = n + 2'd1;
                  bnd = 1'b1;
               end
            end
            scl_pkg::M_ERROR: begin
            end
            default: begin
               bnd = 1'b1;
            end
         endcase
         // byte at a token boundary
         if (bnd) begin
            mode_in = scl_pkg::M_IDLE;
            if (is_blank(data_byte) || data_byte == scl_pkg::CH_NUL) begin
            end else begin
               case (data_byte)
                  scl_pkg::CH_NL: begin
                     set.kind[n] = scl_pkg::TK_NEWLINE;
                     n = n + 2'd1;
                  end
                  scl_pkg::CH_HASH:   mode_in = scl_pkg::M_COMMENT;
                  scl_pkg::CH_PIPE: begin
                     set.kind[n] = scl_pkg::TK_PIPE;
                     n = n + 2'd1;
                  end
                  scl_pkg::CH_LT: begin
                     set.kind[n] = scl_pkg::TK_RIN;
                     n = n + 2'd1;
                  end
                  scl_pkg::CH_GT:     mode_in = scl_pkg::M_GT;
                  scl_pkg::CH_SQUOTE: mode_in = scl_pkg::M_SQ;
                  scl_pkg::CH_DQUOTE: mode_in = scl_pkg::M_DQ;
                  scl_pkg::CH_BSLASH: mode_in = scl_pkg::M_WORD_BS;
                  default: begin
                     set.kind[n] = scl_pkg::TK_CHAR;
                     set.chr[n]  = data_byte;
                     n = n + 2'd1;
                     mode_in = scl_pkg::M_WORD;
                  end
               endcase
            end
         end
      end
      set.count = n;
   end

   // mode register, advanced on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= scl_pkg::M_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

/* sv/scl_resq.sv */
// result register: holds the results of one beat and hands them out in order
module scl_resq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  scl_pkg::lex_set_type  set,
   input  logic                  pop_ready,
   output logic                  can_load,
   output logic                  out_valid,
   output logic [3:0]            out_kind,
   output logic [7:0]            out_chr,
   output logic                  out_last
);

   logic [1:0]                               cnt_ff;
   logic [1:0]                               cnt_in;
   logic [scl_pkg::MAX_RES-1:0][3:0]         kind_ff;
   logic [scl_pkg::MAX_RES-1:0][3:0]         kind_in;
   logic [scl_pkg::MAX_RES-1:0][7:0]         chr_ff;
   logic [scl_pkg::MAX_RES-1:0][7:0]         chr_in;
   logic                                     pop;

   // head slot drives the output
   assign out_valid = (cnt_ff != 2'd0);
   assign out_kind  = kind_ff[0];
   assign out_chr   = chr_ff[0];
   assign out_last  = (cnt_ff == 2'd1);
   assign pop       = out_valid && pop_ready;
   assign can_load  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop_ready);

   // reload on a new beat, else shift down on each taken result
   always_comb begin
      cnt_in  = cnt_ff;
      kind_in = kind_ff;
      chr_in  = chr_ff;
      if (load) begin
         cnt_in  = set.count;
         kind_in = set.kind;
         chr_in  = set.chr;
      end else if (pop) begin
         cnt_in  = cnt_ff - 2'd1;
         for (int i = 0; i < scl_pkg::MAX_RES - 1; i++) begin
            kind_in[i] = kind_ff[i+1];
            chr_in[i]  = chr_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      chr_ff  <= chr_in;
   end

endmodule

/* sv/scl_checker.sv */
// port-level checks of the shell command tokenizer, bound to the top level
module scl_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [15:0]  rsp_tdata,
   input logic         rsp_tlast
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // eof always closes the run of its beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == scl_pkg::TK_EOF |-> rsp_tlast)
      else $error("eof not marked last");

   // only word characters carry a character, padding stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] != scl_pkg::TK_CHAR |-> rsp_tdata[15:4] == 12'd0)
      else $error("non-character token carries data");

   // input stalls only while results are pending
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tlast || rsp_tvalid && !rsp_tready)
      else $error("input stalled with no pending result");

   // an end-of-input beat yields a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == scl_pkg::CMD_END |=> rsp_tvalid)
      else $error("end of input gave no result");

endmodule

bind shell_command_tokenizer scl_checker u_scl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* test/tb_shell_command_tokenizer.sv */
// self-checking testbench for the shell command tokenizer: byte beats in, token beats checked
module tb_shell_command_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   // receiver stall styles
   localparam logic [1:0] RX_ALWAYS  = 2'd0;
   localparam logic [1:0] RX_RANDOM  = 2'd1;
   localparam logic [1:0] RX_PATTERN = 2'd2;

   // cycles with no accepted beat before the run is called hung
   localparam int unsigned QUIET_LIMIT = 2000;
   // cycles watched for stray tokens once nothing is expected
   localparam int unsigned TAIL_CYCLES = 16;
   // long receiver hold-off used to fill the block
   localparam int unsigned HOLD_CYCLES = 400;
   // beats the random line test sends at the least
   localparam int unsigned RANDOM_BEATS = 408;

   typedef struct {
      logic [3:0] kind;
      logic [7:0] chr;
      logic       last;
   } token_type;

   typedef enum {
      PC_WORD, PC_SQUOTED, PC_DQUOTED, PC_ESCAPE, PC_BLANK,
      PC_OPERATOR, PC_COMMENT, PC_NEWLINE, PC_BROKEN
   } piece_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = scl_pkg::CMD_DATA;   // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // [3:0] token_kind, [11:4] word_char, [15:12] zero
   logic        rsp_tlast;

   // predictor state and expected tokens
   logic [3:0]  lex_mode = scl_pkg::M_IDLE;
   token_type   beat_tokens[$];
   token_type   token_queue[$];

   int unsigned fail_count = 0;
   int unsigned beats_sent = 0;
   int unsigned burst_left = 0;
   int unsigned gap_max = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;
   int unsigned rx_cycle = 0;
   int unsigned quiet_cycles = 0;
   logic [1:0]  rx_style = RX_ALWAYS;

   shell_command_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit is_blank(input logic [7:0] ch);
      return ch == scl_pkg::CH_SPACE || ch == scl_pkg::CH_TAB || ch == scl_pkg::CH_VT ||
             ch == scl_pkg::CH_FF || ch == scl_pkg::CH_CR;
   endfunction

   function automatic bit breaks_word(input logic [7:0] ch);
      return is_blank(ch) || ch == scl_pkg::CH_NL || ch == scl_pkg::CH_PIPE ||
             ch == scl_pkg::CH_LT || ch == scl_pkg::CH_GT || ch == scl_pkg::CH_HASH ||
             ch == scl_pkg::CH_NUL;
   endfunction

   function automatic void emit_token(input logic [3:0] kind, input logic [7:0] ch);
      token_type t;
      t.kind = kind;
      t.chr  = (kind == scl_pkg::TK_CHAR) ? ch : 8'h00;
      t.last = 1'b0;
      beat_tokens.push_back(t);
   endfunction

   // byte seen with no word open
   function automatic void lex_boundary(input logic [7:0] ch);
      lex_mode = scl_pkg::M_IDLE;
      if (is_blank(ch) || ch == scl_pkg::CH_NUL)
         return;
      case (ch)
         scl_pkg::CH_NL:     emit_token(scl_pkg::TK_NEWLINE, 8'h00);
         scl_pkg::CH_HASH:   lex_mode = scl_pkg::M_COMMENT;
         scl_pkg::CH_PIPE:   emit_token(scl_pkg::TK_PIPE, 8'h00);
         scl_pkg::CH_LT:     emit_token(scl_pkg::TK_RIN, 8'h00);
         scl_pkg::CH_GT:     lex_mode = scl_pkg::M_GT;
         scl_pkg::CH_SQUOTE: lex_mode = scl_pkg::M_SQ;
         scl_pkg::CH_DQUOTE: lex_mode = scl_pkg::M_DQ;
         scl_pkg::CH_BSLASH: lex_mode = scl_pkg::M_WORD_BS;
         default: begin
            emit_token(scl_pkg::TK_CHAR, ch);
            lex_mode = scl_pkg::M_WORD;
         end
      endcase
   endfunction

   function automatic void lex_data(input logic [7:0] ch);
      case (lex_mode)
         scl_pkg::M_WORD: begin
            if (ch == scl_pkg::CH_SQUOTE)
               lex_mode = scl_pkg::M_SQ;
            else if (ch == scl_pkg::CH_DQUOTE)
               lex_mode = scl_pkg::M_DQ;
            else if (ch == scl_pkg::CH_BSLASH)
               lex_mode = scl_pkg::M_WORD_BS;
            else if (breaks_word(ch)) begin
               emit_token(scl_pkg::TK_WEND, 8'h00);
               lex_boundary(ch);
            end else
               emit_token(scl_pkg::TK_CHAR, ch);
         end
         scl_pkg::M_WORD_BS: begin
            emit_token(scl_pkg::TK_CHAR, ch);
            lex_mode = scl_pkg::M_WORD;
         end
         scl_pkg::M_SQ: begin
            if (ch == scl_pkg::CH_SQUOTE)
               lex_mode = scl_pkg::M_WORD;
            else
               emit_token(scl_pkg::TK_CHAR, ch);
         end
         scl_pkg::M_DQ: begin
            if (ch == scl_pkg::CH_DQUOTE)
               lex_mode = scl_pkg::M_WORD;
            else if (ch == scl_pkg::CH_BSLASH)
               lex_mode = scl_pkg::M_DQ_BS;
            else
               emit_token(scl_pkg::TK_CHAR, ch);
         end
         scl_pkg::M_DQ_BS: begin
            if (ch == scl_pkg::CH_NL) begin
               emit_token(scl_pkg::TK_QERR, 8'h00);
               lex_mode = scl_pkg::M_ERROR;
            end else if (ch == scl_pkg::CH_DQUOTE || ch == scl_pkg::CH_BSLASH ||
                         ch == scl_pkg::CH_DOLLAR || ch == scl_pkg::CH_BTICK) begin
               emit_token(scl_pkg::TK_CHAR, ch);
               lex_mode = scl_pkg::M_DQ;
            end else begin
               emit_token(scl_pkg::TK_CHAR, scl_pkg::CH_BSLASH);
               emit_token(scl_pkg::TK_CHAR, ch);
               lex_mode = scl_pkg::M_DQ;
            end
         end
         scl_pkg::M_COMMENT: begin
            if (ch == scl_pkg::CH_NL) begin
               emit_token(scl_pkg::TK_NEWLINE, 8'h00);
               lex_mode = scl_pkg::M_IDLE;
            end
         end
         scl_pkg::M_GT: begin
            if (ch == scl_pkg::CH_GT) begin
               emit_token(scl_pkg::TK_APPEND, 8'h00);
               lex_mode = scl_pkg::M_IDLE;
            end else begin
               emit_token(scl_pkg::TK_ROUT, 8'h00);
               lex_boundary(ch);
            end
         end
         scl_pkg::M_ERROR: ;
         default: lex_boundary(ch);
      endcase
   endfunction

   // end of input: flush what is open, then eof
   function automatic void lex_end();
      case (lex_mode)
         scl_pkg::M_WORD: emit_token(scl_pkg::TK_WEND, 8'h00);
         scl_pkg::M_WORD_BS: begin
            emit_token(scl_pkg::TK_CHAR, scl_pkg::CH_BSLASH);
            emit_token(scl_pkg::TK_WEND, 8'h00);
         end
         scl_pkg::M_SQ, scl_pkg::M_DQ, scl_pkg::M_DQ_BS:
            emit_token(scl_pkg::TK_QERR, 8'h00);
         scl_pkg::M_GT: emit_token(scl_pkg::TK_ROUT, 8'h00);
         default: ;
      endcase
      emit_token(scl_pkg::TK_EOF, 8'h00);
      lex_mode = scl_pkg::M_IDLE;
   endfunction

   function automatic void predict_tokens(input logic cmd, input logic [7:0] ch);
      beat_tokens.delete();
      if (cmd == scl_pkg::CMD_END)
         lex_end();
      else
         lex_data(ch);
      if (beat_tokens.size() > 0)
         beat_tokens[beat_tokens.size()-1].last = 1'b1;
      foreach (beat_tokens[i])
         token_queue.push_back(beat_tokens[i]);
   endfunction

   // ---------------------------------------------------------------- token checker

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (token_queue.size() == 0) begin
            $error("unexpected token beat: token_kind %0d word_char 0x%02h",
                   rsp_tdata[3:0], rsp_tdata[11:4]);
            fail_count++;
         end else begin
            want = token_queue.pop_front();
            if (rsp_tdata[3:0] !== want.kind) begin
               $error("token_kind: expected %0d, actual %0d", want.kind, rsp_tdata[3:0]);
               fail_count++;
            end
            if (rsp_tdata[11:4] !== want.chr) begin
               $error("word_char: expected 0x%02h, actual 0x%02h", want.chr, rsp_tdata[11:4]);
               fail_count++;
            end
            if (rsp_tdata[15:12] !== 4'h0) begin
               $error("tdata pad: expected 0, actual 0x%01h", rsp_tdata[15:12]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // the stall style, redrawn at random, sets rsp_tready; a requested hold-off overrides it
   always @(posedge clock) begin
      rx_cycle++;
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (rx_cycle % 64 == 0)
         rx_style = 2'($urandom_range(0, 2));
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_style)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 2) != 0);
            default:   rsp_tready <= ((rx_cycle % 7) < 4);
         endcase
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sender

   // one byte beat, with bursts and random gaps
   task automatic send_beat(input logic cmd, input logic [7:0] ch);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max != 0) begin
            gap = $urandom_range(1, gap_max);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tokens(cmd, ch);
      burst_left--;
      beats_sent++;
   endtask

   task automatic send_data(input logic [7:0] ch);
      send_beat(scl_pkg::CMD_DATA, ch);
   endtask

   // data byte is don't-care on end of input, so drive noise there
   task automatic send_end();
      send_beat(scl_pkg::CMD_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic stop_and_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (token_queue.size() != 0);
   endtask

   // ---------------------------------------------------------------- byte pickers

   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (breaks_word(b) || b == scl_pkg::CH_SQUOTE || b == scl_pkg::CH_DQUOTE ||
             b == scl_pkg::CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] pick_except(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
      return c;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0: return scl_pkg::CH_TAB;
         1: return scl_pkg::CH_VT;
         2: return scl_pkg::CH_FF;
         3: return scl_pkg::CH_CR;
         default: return scl_pkg::CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_dq_escape();
      case ($urandom_range(0, 4))
         0: return scl_pkg::CH_DQUOTE;
         1: return scl_pkg::CH_BSLASH;
         2: return scl_pkg::CH_DOLLAR;
         3: return scl_pkg::CH_BTICK;
         default: return pick_except(scl_pkg::CH_NL, scl_pkg::CH_NL);
      endcase
   endfunction

   // one lexical piece of a command line
   task automatic send_piece(input piece_kind_type k);
      int n;
      case (k)
         PC_WORD: begin
            n = $urandom_range(1, 4);
            repeat (n) send_data(pick_plain());
         end
         PC_SQUOTED: begin
            n = $urandom_range(0, 3);
            send_data(scl_pkg::CH_SQUOTE);
            repeat (n) send_data(pick_except(scl_pkg::CH_SQUOTE, scl_pkg::CH_SQUOTE));
            send_data(scl_pkg::CH_SQUOTE);
         end
         PC_DQUOTED: begin
            n = $urandom_range(0, 3);
            send_data(scl_pkg::CH_DQUOTE);
            repeat (n) begin
               if ($urandom_range(0, 2) == 0) begin
                  send_data(scl_pkg::CH_BSLASH);
                  send_data(pick_dq_escape());
               end else
                  send_data(pick_except(scl_pkg::CH_DQUOTE, scl_pkg::CH_BSLASH));
            end
            send_data(scl_pkg::CH_DQUOTE);
         end
         PC_ESCAPE: begin
            send_data(scl_pkg::CH_BSLASH);
            send_data(8'($urandom_range(0, 255)));
         end
         PC_BLANK: send_data(pick_blank());
         PC_OPERATOR: begin
            case ($urandom_range(0, 3))
               0: send_data(scl_pkg::CH_PIPE);
               1: send_data(scl_pkg::CH_LT);
               2: send_data(scl_pkg::CH_GT);
               default: begin
                  send_data(scl_pkg::CH_GT);
                  send_data(scl_pkg::CH_GT);
               end
            endcase
         end
         PC_COMMENT: begin
            n = $urandom_range(0, 3);
            send_data(scl_pkg::CH_HASH);
            repeat (n) send_data(pick_except(scl_pkg::CH_NL, scl_pkg::CH_NL));
            send_data(scl_pkg::CH_NL);
         end
         PC_NEWLINE: send_data(scl_pkg::CH_NL);
         default: begin
            // unclosed quote, escaped newline in double quotes, or a stray nul
            case ($urandom_range(0, 2))
               0: send_data(scl_pkg::CH_SQUOTE);
               1: begin
                  send_data(scl_pkg::CH_DQUOTE);
                  send_data(scl_pkg::CH_BSLASH);
                  send_data(scl_pkg::CH_NL);
               end
               default: send_data(scl_pkg::CH_NUL);
            endcase
         end
      endcase
   endtask

   task automatic send_random_line();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_piece(piece_kind_type'($urandom_range(0, PC_BROKEN)));
      if ($urandom_range(0, 4) != 0)
         send_end();
      // occasional raw noise, end of input included
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // extremes and special cases, one after another
   task automatic test_directed();
      gap_max = 0;
      // max byte word, empty quotes inside it, nul ends it
      send_data(8'hFF);
      send_data(scl_pkg::CH_SQUOTE);
      send_data(scl_pkg::CH_SQUOTE);
      send_data(scl_pkg::CH_NUL);
      // double quotes with a special and a plain escape, then operators
      send_data(scl_pkg::CH_DQUOTE);
      send_data(scl_pkg::CH_BSLASH);
      send_data(scl_pkg::CH_DOLLAR);
      send_data(scl_pkg::CH_BSLASH);
      send_data(pick_plain());
      send_data(scl_pkg::CH_DQUOTE);
      send_data(scl_pkg::CH_GT);
      send_data(scl_pkg::CH_GT);
      send_data(scl_pkg::CH_GT);
      send_data(scl_pkg::CH_PIPE);
      send_data(scl_pkg::CH_LT);
      // comment up to newline
      send_data(scl_pkg::CH_HASH);
      send_data(scl_pkg::CH_NL);
      // escaped newline outside quotes, backslash right before end
      send_data(scl_pkg::CH_BSLASH);
      send_data(scl_pkg::CH_NL);
      send_data(scl_pkg::CH_BSLASH);
      send_end();
      // escaped newline in double quotes is an error; bytes after it are dropped
      send_data(scl_pkg::CH_DQUOTE);
      send_data(scl_pkg::CH_BSLASH);
      send_data(scl_pkg::CH_NL);
      send_end();
      // open quote at end, pending redirect at end
      send_data(scl_pkg::CH_SQUOTE);
      send_end();
      send_data(scl_pkg::CH_GT);
      send_end();
      stop_and_drain();
   endtask

   // receiver holds off while the sender keeps offering escapes in double quotes, most of them two-token beats
   task automatic test_backpressure();
      gap_max = 0;
      hold_request = HOLD_CYCLES;
      send_data(scl_pkg::CH_DQUOTE);
      repeat (12) begin
         send_data(scl_pkg::CH_BSLASH);
         send_data(pick_plain());
      end
      send_data(scl_pkg::CH_DQUOTE);
      send_end();
      stop_and_drain();
   endtask

   // mostly well-formed command lines with random content
   task automatic test_random_lines();
      int unsigned first_beat;
      first_beat = beats_sent;
      while (beats_sent - first_beat < RANDOM_BEATS) begin
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         send_random_line();
      end
      send_end();
      stop_and_drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_lines();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
